[rtl/ldr_counts_to_lux_top_macros.svh]
// Assertion macros for the photoresistor lux converter.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef LDR_COUNTS_TO_LUX_TOP_MACROS_SVH
`define LDR_COUNTS_TO_LUX_TOP_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold at every edge.
`define LDRLUX_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// When the antecedent holds, the consequent must hold in the same cycle.
`define LDRLUX_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define LDRLUX_ASSERT_ALWAYS(label, cond, msg)
`define LDRLUX_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

[rtl/ldrlux_pkg.sv]
`default_nettype none
package ldrlux_pkg;

    localparam int COUNT_W    = 12;
    localparam int SUPPLY_W   = 23;
    localparam int FIXED_W    = 20;
    localparam int SCALE_W    = 24;
    localparam int GAMMA_W    = 16;
    localparam int VOLT_W     = 23;
    localparam int RES_W      = 32;
    localparam int LUX_W      = 32;
    localparam int LOG_W      = 21;
    localparam int FRAC_W     = 16;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam int ADC_FULL_SCALE_DEF = 4095;
    localparam int DARK_LIMIT_UV      = 1000;

    localparam logic [RES_W-1:0]    DARK_OHM      = 32'd10000000;
    localparam logic [SUPPLY_W-1:0] SUPPLY_RST    = 23'd3300000;
    localparam logic [FIXED_W-1:0]  FIXED_RST     = 20'd10000;
    localparam logic [SCALE_W-1:0]  SCALE_RST     = 24'd50000;
    localparam logic [GAMMA_W-1:0]  INV_GAMMA_RST = 16'd5851;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SUPPLY_UV     = 2'd0,
        CFG_FIXED_OHM     = 2'd1,
        CFG_SCALE_OHM     = 2'd2,
        CFG_INV_GAMMA_Q12 = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SUPPLY_W-1:0] supply_uv;
        logic [FIXED_W-1:0]  fixed_resistor_ohm;
        logic [SCALE_W-1:0]  ldr_scale_ohm;
        logic [GAMMA_W-1:0]  inv_gamma_q12;
    } cfg_t;

    typedef struct packed {
        logic [VOLT_W-1:0] volt;
        logic [RES_W-1:0]  res;
    } front_t;

    typedef struct packed {
        logic [VOLT_W-1:0] volt;
        logic [RES_W-1:0]  res;
        logic [LOG_W-1:0]  log_r;
        logic [LOG_W-1:0]  log_a;
    } log_t;

    typedef struct packed {
        logic [VOLT_W-1:0] volt;
        logic [RES_W-1:0]  res;
        logic [LUX_W-1:0]  lux;
        logic              sat;
    } result_t;

    // Bitwise integer square root, used only at elaboration.
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_val;
        logic [63:0] rem;
        res     = '0;
        bit_val = 64'h4000_0000_0000_0000;
        rem     = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_val) begin
                rem = rem - (res + bit_val);
                res = (res >> 1) + bit_val;
            end
            else begin
                res = res >> 1;
            end
            bit_val = bit_val >> 2;
        end
        return res;
    endfunction

    // Q31 value of 2^(2^-k), built by repeated truncated square roots from 2.0.
    function automatic logic [31:0] exp2_root(input int k);
        logic [63:0] root;
        root = 64'h1_0000_0000;
        for (int j = 1; j <= 16; j++) begin
            if (j <= k) begin
                root = isqrt64(root << 31);
            end
        end
        return root[31:0];
    endfunction

endpackage
`default_nettype wire

[rtl/ldr_counts_to_lux_top.sv]
// Photoresistor divider count to illuminance. Each accepted adc_count gives one
// result item with the divider voltage in microvolts, the photoresistor resistance
// in ohms (10 Mohm when the voltage is at or below 1 mV) and the illuminance in
// unsigned Q24.8 lux, clamped to all ones with lux_saturated set when it overflows.
// The block takes one item every clock cycle unless it is stalled. Its depth is set
// by the bit-serial resistance divider (one quotient bit per stage, over DIV_W, the
// resistance numerator width, kept at least one bit wider than the resistance
// output), the sixteen squaring stages of the logarithm and the sixteen multiply
// stages of the power of two; the voltage is a reciprocal multiplication that
// finishes inside the divider stages.
// The pipeline only stalls when its last stage holds a result and the output
// register is full and not being taken. Configuration is written through
// cfg_wr_en/cfg_index/cfg_data and must only change while no item is in flight.
`default_nettype none
`include "ldr_counts_to_lux_top_macros.svh"
module ldr_counts_to_lux_top #(
    parameter int ADC_FULL_SCALE = ldrlux_pkg::ADC_FULL_SCALE_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 adc_valid,
    output logic                                      adc_ready,
    input  wire logic [ldrlux_pkg::COUNT_W-1:0]       adc_count,
    output logic                                      lux_valid,
    input  wire logic                                 lux_ready,
    output logic [ldrlux_pkg::VOLT_W-1:0]             voltage_uv,
    output logic [ldrlux_pkg::RES_W-1:0]              ldr_res_ohm,
    output logic [ldrlux_pkg::LUX_W-1:0]              lux_q8,
    output logic                                      lux_saturated,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [ldrlux_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ldrlux_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ldrlux_pkg::*;

    cfg_t    cfg_reg;
    logic    en;

    logic    front_vld;
    front_t  front_data;
    logic    log_vld;
    log_t    log_data;
    logic    exp_vld;
    result_t exp_data;

    logic    lux_vld_reg;
    result_t out_reg;

    // Configuration registers, one per index; all four indices are used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.supply_uv          <= SUPPLY_RST;
            cfg_reg.fixed_resistor_ohm <= FIXED_RST;
            cfg_reg.ldr_scale_ohm      <= SCALE_RST;
            cfg_reg.inv_gamma_q12      <= INV_GAMMA_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SUPPLY_UV:     cfg_reg.supply_uv          <= cfg_data[SUPPLY_W-1:0];
                CFG_FIXED_OHM:     cfg_reg.fixed_resistor_ohm <= cfg_data[FIXED_W-1:0];
                CFG_SCALE_OHM:     cfg_reg.ldr_scale_ohm      <= cfg_data[SCALE_W-1:0];
                CFG_INV_GAMMA_Q12: cfg_reg.inv_gamma_q12      <= cfg_data[GAMMA_W-1:0];
                default:           cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // The whole pipeline moves together. It holds only when a finished result
    // sits in the last stage and the output register cannot take it; every stage,
    // bubbles included, then holds while the output waits.
    assign en        = !(exp_vld && lux_vld_reg && !lux_ready);
    assign adc_ready = en;

    ldrlux_front #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (adc_valid),
        .in_count  (adc_count),
        .cfg       (cfg_reg),
        .out_valid (front_vld),
        .out_data  (front_data)
    );

    ldrlux_log2 u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_vld),
        .in_data   (front_data),
        .scale_ohm (cfg_reg.ldr_scale_ohm),
        .out_valid (log_vld),
        .out_data  (log_data)
    );

    ldrlux_exp2 u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (log_vld),
        .in_data   (log_data),
        .cfg       (cfg_reg),
        .out_valid (exp_vld),
        .out_data  (exp_data)
    );

    // Output register: holds the last result until lux_ready takes it; lux_ready still reaches the pipeline enable.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lux_vld_reg <= 1'b0;
        end
        else if (en && exp_vld)
        begin
            lux_vld_reg <= 1'b1;
        end
        else if (lux_ready)
        begin
            lux_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && exp_vld)
        begin
            out_reg <= exp_data;
        end
    end

    assign lux_valid      = lux_vld_reg;
    assign voltage_uv     = out_reg.volt;
    assign ldr_res_ohm    = out_reg.res;
    assign lux_q8         = out_reg.lux;
    assign lux_saturated  = out_reg.sat;

    // A clamped result always reads as full scale.
    `LDRLUX_ASSERT_IMPLY(a_sat_full, lux_vld_reg && out_reg.sat, out_reg.lux == '1, "lux not clamped")
    // The resistance is floored to one ohm on every path.
    `LDRLUX_ASSERT_IMPLY(a_res_nonzero, lux_vld_reg, out_reg.res != '0, "zero resistance delivered")
    // A result never waits in the last stage while the output register is free.
    `LDRLUX_ASSERT_ALWAYS(a_no_idle_stall, !(exp_vld && !lux_vld_reg && !adc_ready), "idle stall")

endmodule
`default_nettype wire

[rtl/ldrlux_front.sv]
`default_nettype none
module ldrlux_front #(
    parameter int ADC_FULL_SCALE = ldrlux_pkg::ADC_FULL_SCALE_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire logic [ldrlux_pkg::COUNT_W-1:0]     in_count,
    input  wire ldrlux_pkg::cfg_t                   cfg,
    output logic                                    out_valid,
    output ldrlux_pkg::front_t                      out_data
);
    import ldrlux_pkg::*;

    localparam int FS_W   = $clog2(ADC_FULL_SCALE + 1);
    localparam int CMP_W  = (FS_W > COUNT_W) ? FS_W : COUNT_W;
    localparam int PROD_W = COUNT_W + SUPPLY_W;
    localparam int RNUM_W = FIXED_W + FS_W;
    localparam int DIV_W  = (RNUM_W > RES_W) ? RNUM_W : RES_W + 1;
    localparam int LO_W   = 18;
    localparam int HI_W   = PROD_W - LO_W;
    localparam int RCP_W  = PROD_W + 2 - FS_W;
    localparam int VQ_W   = (RCP_W > VOLT_W) ? RCP_W : VOLT_W + 1;
    localparam int VSUM_W = PROD_W + RCP_W;

    localparam logic [CMP_W-1:0]  FS_C     = CMP_W'(ADC_FULL_SCALE);
    localparam logic [FS_W-1:0]   VDIV     = FS_W'(ADC_FULL_SCALE);
    localparam logic [PROD_W-1:0] VFS      = PROD_W'(ADC_FULL_SCALE);
    localparam logic [PROD_W-1:0] DARK_LIM = PROD_W'(DARK_LIMIT_UV * ADC_FULL_SCALE);
    // Reciprocal of the full scale, scaled by two to the product width and
    // rounded down, so the estimated quotient is low by at most one.
    localparam logic [RCP_W-1:0]  RCP      =
        RCP_W'((64'd1 << PROD_W) / 64'(ADC_FULL_SCALE));

    typedef struct packed {
        logic                   dark;
        logic                   one;
        logic [COUNT_W-1:0]     rdiv;
        logic [PROD_W-1:0]      vnum;
        logic [LO_W+RCP_W-1:0]  vlo;
        logic [HI_W+RCP_W-1:0]  vhi;
        logic [PROD_W-1:0]      vmul;
        logic [VQ_W-1:0]        vq;
        logic [DIV_W-1:0]       rnum;
        logic [COUNT_W-1:0]     rrem;
        logic [DIV_W-1:0]       rq;
    } divs_t;

    logic               s0_vld_reg;
    logic [COUNT_W-1:0] s0_count_reg;
    logic               s1_vld_reg;
    logic [COUNT_W-1:0] s1_count_reg;
    logic [PROD_W-1:0]  s1_prod_reg;
    logic [RNUM_W-1:0]  s1_rnum_reg;
    logic               s1_one_reg;

    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   fs_diff;
    logic               s1_one_next;
    logic [PROD_W-1:0]  s1_prod_next;
    logic [RNUM_W-1:0]  s1_rnum_next;

    logic [DIV_W:0]     div_vld_reg;
    divs_t              div_reg [DIV_W+1];
    divs_t              div0_next;

    front_t             post_next;
    logic               out_vld_reg;
    front_t             out_reg;

    // Products: the voltage numerator and the resistance numerator.
    always_comb
    begin
        cnt_ext      = CMP_W'(s0_count_reg);
        s1_one_next  = (cnt_ext >= FS_C);
        fs_diff      = FS_C - cnt_ext;
        s1_prod_next = PROD_W'(s0_count_reg) * PROD_W'(cfg.supply_uv);
        if (s1_one_next)
        begin
            s1_rnum_next = '0;
        end
        else
        begin
            s1_rnum_next = RNUM_W'(cfg.fixed_resistor_ohm) * RNUM_W'(fs_diff[FS_W-1:0]);
        end
    end

    // The voltage product is split in two halves for the reciprocal multiply.
    always_comb
    begin
        div0_next      = '0;
        div0_next.dark = (s1_count_reg == '0) || (s1_prod_reg <= DARK_LIM);
        div0_next.one  = s1_one_reg;
        div0_next.rdiv = s1_count_reg;
        div0_next.vnum = s1_prod_reg;
        div0_next.vlo  = (LO_W+RCP_W)'(s1_prod_reg[LO_W-1:0]) * (LO_W+RCP_W)'(RCP);
        div0_next.vhi  = (HI_W+RCP_W)'(s1_prod_reg[PROD_W-1:LO_W]) * (HI_W+RCP_W)'(RCP);
        div0_next.rnum = DIV_W'(s1_rnum_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg     <= 1'b0;
            s1_vld_reg     <= 1'b0;
            div_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg     <= in_valid;
            s1_vld_reg     <= s0_vld_reg;
            div_vld_reg[0] <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_count_reg <= in_count;
            s1_count_reg <= s0_count_reg;
            s1_prod_reg  <= s1_prod_next;
            s1_rnum_reg  <= s1_rnum_next;
            s1_one_reg   <= s1_one_next;
            div_reg[0]   <= div0_next;
        end
    end

    // One quotient bit per stage for the restoring resistance divider. The
    // first three stages also finish the voltage: they add the partial
    // products, multiply the estimate back, then correct it by one.
    for (genvar k = 0; k < DIV_W; k++)
    begin : g_div
        logic [COUNT_W:0]        rtry;
        logic [COUNT_W:0]        rsub;
        logic [VSUM_W-1:0]       vsum;
        logic [RCP_W+FS_W-1:0]   vprod;
        logic [PROD_W-1:0]       vdiff;
        divs_t                   step_next;

        always_comb
        begin
            step_next      = div_reg[k];
            rtry           = {div_reg[k].rrem, div_reg[k].rnum[DIV_W-1]};
            rsub           = rtry - {1'b0, div_reg[k].rdiv};
            vsum           = VSUM_W'(div_reg[k].vlo) + (VSUM_W'(div_reg[k].vhi) << LO_W);
            vprod          = (RCP_W+FS_W)'(div_reg[k].vq[RCP_W-1:0]) * (RCP_W+FS_W)'(VDIV);
            vdiff          = div_reg[k].vnum - div_reg[k].vmul;
            step_next.rnum = div_reg[k].rnum << 1;
            if (rtry >= {1'b0, div_reg[k].rdiv})
            begin
                step_next.rrem = rsub[COUNT_W-1:0];
                step_next.rq   = {div_reg[k].rq[DIV_W-2:0], 1'b1};
            end
            else
            begin
                step_next.rrem = rtry[COUNT_W-1:0];
                step_next.rq   = {div_reg[k].rq[DIV_W-2:0], 1'b0};
            end
            if (k == 0)
            begin
                step_next.vq = VQ_W'(vsum[VSUM_W-1:PROD_W]);
            end
            if (k == 1)
            begin
                step_next.vmul = vprod[PROD_W-1:0];
            end
            if (k == 2 && vdiff >= VFS)
            begin
                step_next.vq = div_reg[k].vq + VQ_W'(1);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                div_vld_reg[k+1] <= div_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[k+1] <= step_next;
            end
        end
    end

    // Saturation and the dark and full-scale cases.
    always_comb
    begin
        if (|div_reg[DIV_W].vq[VQ_W-1:VOLT_W])
        begin
            post_next.volt = '1;
        end
        else
        begin
            post_next.volt = div_reg[DIV_W].vq[VOLT_W-1:0];
        end
        if (div_reg[DIV_W].dark)
        begin
            post_next.res = DARK_OHM;
        end
        else if (div_reg[DIV_W].one || (div_reg[DIV_W].rq == '0))
        begin
            post_next.res = RES_W'(1);
        end
        else if (|div_reg[DIV_W].rq[DIV_W-1:RES_W])
        begin
            post_next.res = '1;
        end
        else
        begin
            post_next.res = div_reg[DIV_W].rq[RES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= div_vld_reg[DIV_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= post_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

[rtl/ldrlux_log2.sv]
`default_nettype none
module ldrlux_log2 (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire ldrlux_pkg::front_t                in_data,
    input  wire logic [ldrlux_pkg::SCALE_W-1:0]    scale_ohm,
    output logic                                   out_valid,
    output ldrlux_pkg::log_t                       out_data
);
    import ldrlux_pkg::*;

    localparam int STEPS = FRAC_W;

    typedef struct packed {
        logic [VOLT_W-1:0] volt;
        logic [RES_W-1:0]  res;
        logic [31:0]       mr;
        logic [31:0]       ma;
        logic [4:0]        ir;
        logic [4:0]        ia;
        logic [FRAC_W-1:0] fr;
        logic [FRAC_W-1:0] fa;
    } lg_t;

    logic [STEPS:0] lg_vld_reg;
    lg_t            lg_reg [STEPS+1];
    lg_t            lg0_next;
    logic [31:0]    a_ext;
    logic           out_vld_reg;
    log_t           out_reg;
    log_t           out_next;

    function automatic logic [4:0] msb_pos(input logic [31:0] x);
        logic [4:0] p;
        p = '0;
        for (int i = 1; i < 32; i++)
        begin
            if (x[i])
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    // Integer part and normalized mantissa of both operands.
    always_comb
    begin
        a_ext         = 32'(scale_ohm);
        lg0_next.volt = in_data.volt;
        lg0_next.res  = in_data.res;
        lg0_next.ir   = msb_pos(in_data.res);
        lg0_next.ia   = msb_pos(a_ext);
        lg0_next.mr   = in_data.res << (5'd31 - lg0_next.ir);
        lg0_next.ma   = a_ext << (5'd31 - lg0_next.ia);
        lg0_next.fr   = '0;
        lg0_next.fa   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            lg_vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lg_reg[0] <= lg0_next;
        end
    end

    // Each stage squares both mantissas and yields one fraction bit of each.
    for (genvar k = 0; k < STEPS; k++)
    begin : g_sq
        logic [63:0] sq_r;
        logic [63:0] sq_a;
        logic [32:0] t_r;
        logic [32:0] t_a;
        lg_t         step_next;

        always_comb
        begin
            step_next = lg_reg[k];
            sq_r      = 64'(lg_reg[k].mr) * 64'(lg_reg[k].mr);
            sq_a      = 64'(lg_reg[k].ma) * 64'(lg_reg[k].ma);
            t_r       = sq_r[63:31];
            t_a       = sq_a[63:31];
            step_next.fr = {lg_reg[k].fr[FRAC_W-2:0], t_r[32]};
            step_next.fa = {lg_reg[k].fa[FRAC_W-2:0], t_a[32]};
            step_next.mr = t_r[32] ? t_r[32:1] : t_r[31:0];
            step_next.ma = t_a[32] ? t_a[32:1] : t_a[31:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                lg_vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                lg_vld_reg[k+1] <= lg_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lg_reg[k+1] <= step_next;
            end
        end
    end

    always_comb
    begin
        out_next.volt  = lg_reg[STEPS].volt;
        out_next.res   = lg_reg[STEPS].res;
        out_next.log_r = {lg_reg[STEPS].ir, lg_reg[STEPS].fr};
        out_next.log_a = {lg_reg[STEPS].ia, lg_reg[STEPS].fa};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= lg_vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

[rtl/ldrlux_exp2.sv]
`default_nettype none
module ldrlux_exp2 (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire ldrlux_pkg::log_t      in_data,
    input  wire ldrlux_pkg::cfg_t      cfg,
    output logic                       out_valid,
    output ldrlux_pkg::result_t        out_data
);
    import ldrlux_pkg::*;

    localparam int STEPS = FRAC_W;
    localparam int D_W   = LOG_W + 1;
    localparam int P_W   = D_W + GAMMA_W + 1;

    typedef struct packed {
        logic [VOLT_W-1:0] volt;
        logic [RES_W-1:0]  res;
        logic              sat;
        logic              neg;
        logic [4:0]        ish;
        logic [FRAC_W-1:0] f;
        logic [31:0]       m;
    } ex_t;

    logic                   x0_vld_reg;
    logic [VOLT_W-1:0]      x0_volt_reg;
    logic [RES_W-1:0]       x0_res_reg;
    logic signed [P_W-1:0]  x0_prod_reg;
    logic signed [D_W-1:0]  d_val;
    logic signed [P_W-1:0]  prod_next;

    logic signed [P_W:0]    rnd;
    logic signed [P_W-12:0] e_val;
    logic signed [P_W-11:0] t_val;
    logic signed [P_W-27:0] ip;

    logic [STEPS:0] ex_vld_reg;
    ex_t            ex_reg [STEPS+1];
    ex_t            ex0_next;

    result_t        out_next;
    logic           out_vld_reg;
    result_t        out_reg;

    // Exponent difference times the reciprocal exponent.
    always_comb
    begin
        d_val     = $signed({1'b0, in_data.log_a}) - $signed({1'b0, in_data.log_r});
        prod_next = P_W'(d_val) * P_W'($signed({1'b0, cfg.inv_gamma_q12}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x0_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            x0_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_volt_reg <= in_data.volt;
            x0_res_reg  <= in_data.res;
            x0_prod_reg <= prod_next;
        end
    end

    // Round half up to Q16, add the Q8 output offset, split integer and fraction.
    always_comb
    begin
        rnd            = (P_W+1)'(x0_prod_reg) + (P_W+1)'(2048);
        e_val          = rnd[P_W:12];
        t_val          = (P_W-10)'(e_val) + (P_W-10)'(32'sd524288);
        ip             = t_val[P_W-11:16];
        ex0_next.volt  = x0_volt_reg;
        ex0_next.res   = x0_res_reg;
        ex0_next.neg   = ip[P_W-27];
        ex0_next.sat   = !ip[P_W-27] && (|ip[P_W-28:5]);
        ex0_next.ish   = ip[4:0];
        ex0_next.f     = t_val[15:0];
        ex0_next.m     = 32'h8000_0000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            ex_vld_reg[0] <= x0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg[0] <= ex0_next;
        end
    end

    // Stage j multiplies by the root for fraction bit j, from the top bit down.
    for (genvar j = 0; j < STEPS; j++)
    begin : g_root
        localparam logic [31:0] ROOT = exp2_root(j + 1);
        logic [63:0] mul;
        ex_t         step_next;

        always_comb
        begin
            step_next = ex_reg[j];
            mul       = 64'(ex_reg[j].m) * 64'(ROOT);
            if (ex_reg[j].f[FRAC_W-1-j])
            begin
                step_next.m = mul[62:31];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ex_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                ex_vld_reg[j+1] <= ex_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ex_reg[j+1] <= step_next;
            end
        end
    end

    // Scale by the integer part; zero scale or negative exponent gives zero lux.
    always_comb
    begin
        out_next.volt = ex_reg[STEPS].volt;
        out_next.res  = ex_reg[STEPS].res;
        out_next.sat  = 1'b0;
        if (cfg.ldr_scale_ohm == '0 || ex_reg[STEPS].neg)
        begin
            out_next.lux = '0;
        end
        else if (ex_reg[STEPS].sat)
        begin
            out_next.lux = '1;
            out_next.sat = 1'b1;
        end
        else
        begin
            out_next.lux = ex_reg[STEPS].m >> (~ex_reg[STEPS].ish);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= ex_vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ldrlux_pkg::*;

    // Settle time is kept well above the pipeline depth at the default full scale.
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int ITEMS_PER_SET = 100;
    localparam int FULL_SCALE    = ADC_FULL_SCALE_DEF;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 adc_valid = 1'b0;
    logic                 adc_ready;
    logic [COUNT_W-1:0]   adc_count = '0;
    logic                 lux_valid;
    logic                 lux_ready = 1'b0;
    logic [VOLT_W-1:0]    voltage_uv;
    logic [RES_W-1:0]     ldr_res_ohm;
    logic [LUX_W-1:0]     lux_q8;
    logic                 lux_saturated;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ldr_counts_to_lux_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .adc_valid      (adc_valid),
        .adc_ready      (adc_ready),
        .adc_count      (adc_count),
        .lux_valid      (lux_valid),
        .lux_ready      (lux_ready),
        .voltage_uv     (voltage_uv),
        .ldr_res_ohm    (ldr_res_ohm),
        .lux_q8         (lux_q8),
        .lux_saturated  (lux_saturated),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The testbench keeps its own copy of the register file. It starts at the reset
    // values and then only changes together with a register write, while nothing is in flight.
    cfg_t    light_cfg;
    result_t pending_lux[$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      steady_flow = 1'b0;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > v)
        begin
            probe = probe >> 2;
        end
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Truncated base-two logarithm in Q16: the msb position, then sixteen
    // fraction bits from repeated squaring of a Q31 mantissa.
    function automatic longint log2_fixed(input logic [31:0] x);
        int              msb;
        longint unsigned mant;
        logic [15:0]     frac;
        msb  = 0;
        frac = '0;
        while (msb < 31 && (x >> (msb + 1)) != 0)
        begin
            msb++;
        end
        mant = longint'(x) << (31 - msb);
        for (int i = 0; i < 16; i++)
        begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= 64'h1_0000_0000)
            begin
                frac[0] = 1'b1;
                mant    = mant >> 1;
            end
        end
        return (longint'(msb) << 16) | longint'(frac);
    endfunction

    // Fractional power of two in Q31, one chained root per set fraction bit.
    function automatic longint unsigned pow2_frac(input logic [15:0] frac);
        longint unsigned root;
        longint unsigned acc;
        root = 64'h1_0000_0000;
        acc  = 64'h8000_0000;
        for (int k = 1; k <= 16; k++)
        begin
            root = int_sqrt(root << 31);
            if (frac[16-k])
            begin
                acc = (acc * root) >> 31;
            end
        end
        return acc;
    endfunction

    function automatic result_t predict_lux(input logic [COUNT_W-1:0] count);
        result_t         r;
        longint unsigned prod;
        longint unsigned volt;
        longint unsigned ohm;
        longint          diff;
        longint          expo;
        longint          whole;
        longint unsigned mant;
        longint unsigned lux;
        prod = longint'(count) * longint'(light_cfg.supply_uv);
        volt = prod / FULL_SCALE;
        if (volt > 64'h7F_FFFF)
        begin
            volt = 64'h7F_FFFF;
        end
        if (count == 0 || prod <= longint'(DARK_LIMIT_UV) * FULL_SCALE)
        begin
            ohm = DARK_OHM;
        end
        else if (count >= FULL_SCALE)
        begin
            ohm = 1;
        end
        else
        begin
            ohm = longint'(light_cfg.fixed_resistor_ohm) * (FULL_SCALE - count) / count;
            if (ohm < 1)
            begin
                ohm = 1;
            end
            if (ohm > 64'hFFFF_FFFF)
            begin
                ohm = 64'hFFFF_FFFF;
            end
        end
        r.volt = volt[VOLT_W-1:0];
        r.res  = ohm[RES_W-1:0];
        r.lux  = '0;
        r.sat  = 1'b0;
        if (light_cfg.ldr_scale_ohm != 0)
        begin
            diff  = log2_fixed(32'(light_cfg.ldr_scale_ohm)) - log2_fixed(ohm[31:0]);
            // Arithmetic shifts of signed values floor, as the exponent rounding needs.
            expo  = ((diff * longint'(light_cfg.inv_gamma_q12) + 2048) >>> 12) + 8 * 65536;
            whole = expo >>> 16;
            if (whole >= 32)
            begin
                r.lux = '1;
                r.sat = 1'b1;
            end
            else
            begin
                mant = pow2_frac(expo[15:0]);
                if (whole >= 0)
                begin
                    lux = (mant << whole) >> 31;
                end
                else if (31 - whole >= 64)
                begin
                    lux = 0;
                end
                else
                begin
                    lux = mant >> (31 - whole);
                end
                r.lux = lux[31:0];
            end
        end
        return r;
    endfunction

    // Writes all four registers, one per cycle, and updates the local copy.
    task automatic load_light_cfg(input cfg_t c);
        cfg_index_t idx;
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_index_t'(i);
            @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            case (idx)
                CFG_SUPPLY_UV:     cfg_data <= CFG_DATA_W'(c.supply_uv);
                CFG_FIXED_OHM:     cfg_data <= CFG_DATA_W'(c.fixed_resistor_ohm);
                CFG_SCALE_OHM:     cfg_data <= CFG_DATA_W'(c.ldr_scale_ohm);
                CFG_INV_GAMMA_Q12: cfg_data <= CFG_DATA_W'(c.inv_gamma_q12);
                default:           cfg_data <= '0;
            endcase
        end
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        light_cfg = c;
    endtask

    // Offers one count and records the prediction when it is accepted. The valid
    // line is only lowered when a gap follows, so it is never dropped and raised
    // in the same step.
    task automatic send_count(input logic [COUNT_W-1:0] count, input bit typed,
                              input logic [VOLT_W-1:0] volt, input logic [RES_W-1:0] ohm);
        int      gap;
        result_t r;
        gap = steady_flow ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            adc_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        adc_valid <= 1'b1;
        adc_count <= count;
        do
        begin
            @(posedge clk);
        end
        while (!adc_ready);
        r = predict_lux(count);
        if (typed)
        begin
            r.volt = volt;
            r.res  = ohm;
        end
        pending_lux.push_back(r);
    endtask

    // Waits for every outstanding item, then lets the pipeline settle.
    task automatic drain_results();
        adc_valid <= 1'b0;
        while (pending_lux.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return COUNT_W'($urandom_range(0, 3));
            1:       return COUNT_W'($urandom_range(4090, 4095));
            2:       return COUNT_W'($urandom_range(0, 40));
            default: return COUNT_W'($urandom);
        endcase
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.supply_uv          = SUPPLY_W'($urandom_range(1, 5000000));
        c.fixed_resistor_ohm = FIXED_W'($urandom_range(1, 1000000));
        c.ldr_scale_ohm      = SCALE_W'($urandom_range(1, 10000000));
        c.inv_gamma_q12      = GAMMA_W'($urandom_range(410, 40960));
        if ($urandom_range(0, 3) == 0)
        begin
            c = cfg_t'({$urandom, $urandom, $urandom});
        end
        return c;
    endfunction

    // Results are taken at random: ready is held low for a random stall before each
    // item, except in steady stretches.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                lux_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            lux_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!lux_valid);
        end
    end

    // Every accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && lux_valid && lux_ready)
        begin
            if (pending_lux.size() == 0)
            begin
                $display("%0t: unexpected item volt=%0d res=%0d lux=%0h sat=%0b", $realtime,
                         voltage_uv, ldr_res_ohm, lux_q8, lux_saturated);
                error_count++;
            end
            else
            begin
                want = pending_lux.pop_front();
                if (voltage_uv !== want.volt)
                begin
                    $display("%0t: voltage_uv expected %0d actual %0d", $realtime,
                             want.volt, voltage_uv);
                    error_count++;
                end
                if (ldr_res_ohm !== want.res)
                begin
                    $display("%0t: ldr_res_ohm expected %0d actual %0d", $realtime,
                             want.res, ldr_res_ohm);
                    error_count++;
                end
                if (lux_q8 !== want.lux)
                begin
                    $display("%0t: lux_q8 expected %0h actual %0h", $realtime,
                             want.lux, lux_q8);
                    error_count++;
                end
                if (lux_saturated !== want.sat)
                begin
                    $display("%0t: lux_saturated expected %0b actual %0b", $realtime,
                             want.sat, lux_saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    typedef struct {
        logic [COUNT_W-1:0] count;
        bit                 typed;
        logic [VOLT_W-1:0]  volt;
        logic [RES_W-1:0]   ohm;
    } count_row_t;

    // Directed counts under the reset register values. Voltage and resistance are
    // typed in where they are obvious: zero and tiny counts are dark, and full
    // scale gives the full supply and the one ohm floor.
    count_row_t directed_rows[] = '{
        '{12'd0,    1'b1, 23'd0,       DARK_OHM},
        '{12'd1,    1'b1, 23'd805,     DARK_OHM},
        '{12'd4095, 1'b1, 23'd3300000, 32'd1},
        '{12'd4094, 1'b0, '0, '0},
        '{12'd2,    1'b0, '0, '0},
        '{12'd2048, 1'b0, '0, '0},
        '{12'd2047, 1'b0, '0, '0},
        '{12'hAAA,  1'b0, '0, '0},
        '{12'h555,  1'b0, '0, '0},
        '{12'd1241, 1'b0, '0, '0}
    };

    // Register sets walked in turn: reset values, the extremes of every range, a zero supply,
    // a zero scale, a zero resistor with a zero exponent, a mixed extreme, then random sets.
    cfg_t fixed_sets[] = '{
        '{SUPPLY_RST, FIXED_RST, SCALE_RST, INV_GAMMA_RST},
        '{23'h7FFFFF, 20'hFFFFF, 24'hFFFFFF, 16'hFFFF},
        '{23'd1, 20'd1, 24'd1, 16'd410},
        '{23'd5000000, 20'd1000000, 24'd10000000, 16'd40960},
        '{23'd0, FIXED_RST, SCALE_RST, INV_GAMMA_RST},
        '{SUPPLY_RST, FIXED_RST, 24'd0, INV_GAMMA_RST},
        '{SUPPLY_RST, 20'd0, SCALE_RST, 16'd0},
        '{23'd1, 20'hFFFFF, 24'd1, 16'hFFFF}
    };

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        light_cfg = '{SUPPLY_RST, FIXED_RST, SCALE_RST, INV_GAMMA_RST};
        @(posedge clk);

        // Directed items run before any register write, against the reset values.
        foreach (directed_rows[i])
        begin
            send_count(directed_rows[i].count, directed_rows[i].typed,
                       directed_rows[i].volt, directed_rows[i].ohm);
        end
        send_count(12'd1000, 1'b0, '0, '0);
        drain_results();

        // Each register set is loaded only after the pipeline has emptied; the
        // sender thus pauses until every outstanding item has come back.
        for (int set = 0; set < 14; set++)
        begin
            load_light_cfg(set < fixed_sets.size() ? fixed_sets[set] : random_cfg());
            steady_flow = (set % 4 == 3);
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                send_count(pick_count(), 1'b0, '0, '0);
            end
            drain_results();
            steady_flow = 1'b0;
        end

        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
